// ===== sv/tdf_pkg.sv =====
// ----------------------------------------------------------------------------
// tdf_pkg
// Types and constants shared by the tracking differentiator modules.
// ----------------------------------------------------------------------------
package tdf_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_STEP  = 2'd2;

    localparam int CFG_DATA_W = 32;
    localparam int STEP_W     = 24;
    localparam int SPEED_W    = 32;

    localparam logic [STEP_W-1:0]  STEP_TIME_RESET    = 24'd16777;
    localparam logic [SPEED_W-1:0] SPEED_FACTOR_RESET = 32'd6553600;
    localparam logic [STEP_W-1:0]  FILTER_STEP_RESET  = 24'd16777;

    // Fraction bits of the Q0.24 factors.
    localparam int FRAC_W = 24;

    // Shared multiplier: a 32-bit second operand taken 8 bits per cycle.
    localparam int MUL_B_W     = 32;
    localparam int MUL_DIGIT_W = 8;
    localparam int MUL_STEPS   = MUL_B_W / MUL_DIGIT_W;

    // Dividend width of the acceleration divide (32-bit speed factor times 32-bit magnitude of the fhan argument).
    localparam int DIV_BITS = 64;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_MWAIT,
        S_PREP,
        S_ROOT,
        S_HALF,
        S_AREG,
        S_ASEL,
        S_DIV,
        S_OUT
    } state_t;

    // Which product the shared multiplier is forming.
    typedef enum logic [2:0] {
        MS_H0SQ,
        MS_GAIN,
        MS_A0,
        MS_RAD,
        MS_QN,
        MS_POS,
        MS_RATE
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_start;
        logic     mul_take;
        logic     root_start;
        logic     div_start;
        logic     y_take;
        logic     half_take;
        logic     a_take;
        logic     fh_sat;
        logic     fh_take;
        logic     out_load;
        mul_sel_t sel;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic iter_done;
        logic a_in_range;
        logic out_free;
    } status_t;

endpackage

// ===== sv/tracking_differentiator_fhan.sv =====
// ----------------------------------------------------------------------------
// tracking_differentiator_fhan
// Fixed-point tracking differentiator built on the time-optimal fhan function.
// ----------------------------------------------------------------------------
// Each target beat (signed Q16.16) updates the tracked value and its
// derivative and yields one result beat holding both, saturated to 32 bits.
// Items are processed one at a time. The work per item is up to seven passes
// through the shared 8-bit-per-cycle multiplier, the bit-serial square root
// (RW/2 steps, 35 at DATA_WIDTH 32 and 43 at 48) and, when the fhan argument
// lies in its linear zone, the 64-step restoring divide. The next target is
// taken as soon as the result is in the output register, even if that beat
// has not yet been taken.
// Configuration writes are accepted in every cycle and must only be issued
// while no item is in flight.
// ----------------------------------------------------------------------------
module tracking_differentiator_fhan #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tdf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tdf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [31:0]                s_target,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [31:0]                m_tracked_value,
    output logic signed [31:0]                m_tracked_rate
);
    tdf_pkg::cmd_t    cmd;
    tdf_pkg::status_t status;

    assign cfg_ready = 1'b1;

    tdf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tdf_dp #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_target        (s_target),
        .m_ready         (m_ready),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_valid),
        .m_tracked_value (m_tracked_value),
        .m_tracked_rate  (m_tracked_rate)
    );

endmodule

// ===== sv/tdf_mul.sv =====
// ----------------------------------------------------------------------------
// tdf_mul
// Unsigned multi-cycle multiplier, one 8-bit digit of the second operand per
// cycle, most significant digit first.
// ----------------------------------------------------------------------------
module tdf_mul #(
    parameter int AW = 37
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic [AW-1:0]                          a,
    input  logic [tdf_pkg::MUL_B_W-1:0]            b,
    output logic                                   busy,
    output logic                                   done,
    output logic [AW+tdf_pkg::MUL_B_W-1:0]         prod
);
    localparam int PW  = AW + tdf_pkg::MUL_B_W;
    localparam int DG  = tdf_pkg::MUL_DIGIT_W;
    localparam int BW  = tdf_pkg::MUL_B_W;
    localparam int SCW = $clog2(tdf_pkg::MUL_STEPS + 1);

    logic [AW-1:0]  a_reg;
    logic [BW-1:0]  b_reg;
    logic [PW-1:0]  acc_reg, acc_next;
    logic [SCW-1:0] cnt_reg;
    logic           busy_reg, done_reg;
    logic [AW+DG-1:0] part;

    assign part     = a_reg * b_reg[BW-1 -: DG];
    assign acc_next = (acc_reg << DG) + PW'(part);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= SCW'(tdf_pkg::MUL_STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == SCW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            b_reg   <= b_reg << DG;
            acc_reg <= acc_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== sv/tdf_dp.sv =====
// ----------------------------------------------------------------------------
// tdf_dp
// Datapath: configuration registers, filter state, the shared multiplier, a
// bit-serial root and divide unit, and the output register.
// ----------------------------------------------------------------------------
module tdf_dp #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    input  logic [tdf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [tdf_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic signed [31:0]                    s_target,
    input  logic                                  m_ready,
    input  tdf_pkg::cmd_t                         cmd,
    output tdf_pkg::status_t                      status,
    output logic                                  m_valid,
    output logic signed [31:0]                    m_tracked_value,
    output logic signed [31:0]                    m_tracked_rate
);
    localparam int DW   = DATA_WIDTH;
    localparam int XW   = (DW > 32) ? DW : 32;
    localparam int AW   = XW + 5;
    localparam int PW   = AW + tdf_pkg::MUL_B_W;
    localparam int RW   = 2 * ((XW + 38) / 2);
    localparam int RTW  = RW / 2;
    localparam int QW   = (RTW > tdf_pkg::DIV_BITS) ? RTW : tdf_pkg::DIV_BITS;
    localparam int REMW = RTW + 2;
    localparam int CW   = $clog2(QW + 1);
    localparam int SAW  = ((RTW > XW) ? RTW : XW) + 2;
    localparam int NW   = ((DW > 33) ? DW : 33) + 1;
    localparam int FW   = tdf_pkg::FRAC_W;
    localparam int SW   = tdf_pkg::STEP_W;
    localparam int GW   = tdf_pkg::SPEED_W;

    logic [SW-1:0] step_reg, filt_reg;
    logic [GW-1:0] speed_reg;
    logic signed [DW-1:0] pos_reg, rate_reg;

    logic signed [XW:0]   err_reg;
    logic [SW-1:0]        h0sq_reg;
    logic [31:0]          d_reg;
    logic signed [DW-1:0] a0_reg;
    logic signed [XW+1:0] y_reg;
    logic [RTW-1:0]       half_reg;
    logic signed [SAW-1:0] a_reg;
    logic                 fhneg_reg;
    logic [31:0]          fhmag_reg;

    logic [RW-1:0]   src_reg;
    logic [REMW:0]   rem_reg;
    logic [QW-1:0]   res_reg;
    logic [CW-1:0]   cnt_reg;
    logic            ibusy_reg, iroot_reg, idone_reg;

    logic                mv_reg;
    logic signed [31:0]  tv_reg, tr_reg;

    logic [AW-1:0]          mul_a;
    logic [tdf_pkg::MUL_B_W-1:0] mul_b;
    logic [PW-1:0]          prod;
    logic                   mul_busy, mul_done;

    logic [DW-1:0]   rate_mag;
    logic [XW:0]     y_mag;
    logic [31:0]     a_mag;
    logic [31:0]     gain;
    logic [DW-1:0]   pmag;
    logic signed [NW-1:0] pos_sum, rate_sum;
    logic signed [SAW-1:0] d_sa, y_sa, a0_sa, a0y, a2;
    logic signed [XW+1:0] d_sy;
    logic            y_in;

    logic [REMW+2:0] sh, trial;
    logic            ge;

    function automatic logic signed [DW-1:0] sat_dw(input logic signed [NW-1:0] v);
        logic [NW-DW:0] top;
        top = v[NW-1:DW-1];
        if (top == '0 || top == '1) begin
            return v[DW-1:0];
        end else if (v[NW-1]) begin
            return {1'b1, {(DW-1){1'b0}}};
        end else begin
            return {1'b0, {(DW-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [DW-1:0] s);
        logic signed [XW:0] v;
        logic [XW-31:0]     top;
        v   = {{(XW+1-DW){s[DW-1]}}, s};
        top = v[XW:31];
        if (top == '0 || top == '1) begin
            return v[31:0];
        end else if (v[XW]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7fff_ffff;
        end
    endfunction

    // ------------------------------------------------------------------
    // Operand selection for the shared multiplier
    // ------------------------------------------------------------------
    assign rate_mag = rate_reg[DW-1] ? DW'(-rate_reg) : DW'(rate_reg);
    assign y_mag    = y_reg[XW+1] ? (XW+1)'(-y_reg) : (XW+1)'(y_reg);
    assign a_mag    = a_reg[SAW-1] ? 32'(-a_reg) : 32'(a_reg);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.sel)
            tdf_pkg::MS_H0SQ: begin
                mul_a = AW'(filt_reg);
                mul_b = 32'(filt_reg);
            end
            tdf_pkg::MS_GAIN: begin
                mul_a = AW'(speed_reg);
                mul_b = 32'(h0sq_reg);
            end
            tdf_pkg::MS_A0: begin
                mul_a = AW'(rate_mag);
                mul_b = 32'(filt_reg);
            end
            tdf_pkg::MS_RAD: begin
                mul_a = AW'(d_reg) + (AW'(y_mag) << 3);
                mul_b = d_reg;
            end
            tdf_pkg::MS_QN: begin
                mul_a = AW'(speed_reg);
                mul_b = a_mag;
            end
            tdf_pkg::MS_POS: begin
                mul_a = AW'(rate_mag);
                mul_b = 32'(step_reg);
            end
            tdf_pkg::MS_RATE: begin
                mul_a = AW'(fhmag_reg);
                mul_b = 32'(step_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    tdf_mul #(.AW(AW)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .prod    (prod)
    );

    assign gain     = prod[FW+31:FW];
    assign pmag     = prod[FW+DW-1:FW];
    assign pos_sum  = rate_reg[DW-1] ? (NW'(pos_reg) - NW'(signed'({1'b0, pmag})))
                                     : (NW'(pos_reg) + NW'(signed'({1'b0, pmag})));
    assign rate_sum = fhneg_reg ? (NW'(rate_reg) - NW'(signed'({1'b0, gain})))
                                : (NW'(rate_reg) + NW'(signed'({1'b0, gain})));

    // ------------------------------------------------------------------
    // Selection of the fhan argument a
    // ------------------------------------------------------------------
    assign d_sa  = SAW'(signed'({1'b0, d_reg}));
    assign d_sy  = (XW+2)'(signed'({1'b0, d_reg}));
    assign y_sa  = SAW'(y_reg);
    assign a0_sa = SAW'(a0_reg);
    assign y_in  = (y_reg >= -d_sy) && (y_reg < d_sy);
    assign a0y   = a0_sa + y_sa;
    assign a2    = y_reg[XW+1] ? (a0_sa - SAW'(signed'({1'b0, half_reg})))
                               : (a0_sa + SAW'(signed'({1'b0, half_reg})));

    // ------------------------------------------------------------------
    // Bit-serial unit: restoring square root (two radicand bits per step)
    // or restoring divide by d (one dividend bit per step).
    // ------------------------------------------------------------------
    always_comb begin
        if (iroot_reg) begin
            sh    = {rem_reg, src_reg[RW-1:RW-2]};
            trial = (REMW+3)'({res_reg[RTW-1:0], 2'b01});
        end else begin
            sh    = {1'b0, rem_reg, src_reg[RW-1]};
            trial = (REMW+3)'(d_reg);
        end
        ge = (sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ibusy_reg <= 1'b0;
            idone_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            idone_reg <= 1'b0;
            if (cmd.root_start) begin
                ibusy_reg <= 1'b1;
                cnt_reg   <= CW'(RTW);
            end else if (cmd.div_start) begin
                ibusy_reg <= 1'b1;
                cnt_reg   <= CW'(tdf_pkg::DIV_BITS);
            end else if (ibusy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    ibusy_reg <= 1'b0;
                    idone_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.root_start) begin
            iroot_reg <= 1'b1;
            src_reg   <= RW'(prod);
            rem_reg   <= '0;
            res_reg   <= '0;
        end else if (cmd.div_start) begin
            iroot_reg <= 1'b0;
            src_reg   <= {prod[tdf_pkg::DIV_BITS-1:0], {(RW-tdf_pkg::DIV_BITS){1'b0}}};
            rem_reg   <= '0;
            res_reg   <= '0;
        end else if (ibusy_reg) begin
            src_reg <= iroot_reg ? (src_reg << 2) : (src_reg << 1);
            rem_reg <= ge ? (REMW+1)'(sh - trial) : (REMW+1)'(sh);
            res_reg <= {res_reg[QW-2:0], ge};
        end
    end

    // ------------------------------------------------------------------
    // Configuration, filter state and output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= tdf_pkg::STEP_TIME_RESET;
            speed_reg <= tdf_pkg::SPEED_FACTOR_RESET;
            filt_reg  <= tdf_pkg::FILTER_STEP_RESET;
            pos_reg   <= '0;
            rate_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    tdf_pkg::CFG_STEP_TIME:    step_reg  <= cfg_data[SW-1:0];
                    tdf_pkg::CFG_SPEED_FACTOR: speed_reg <= cfg_data[GW-1:0];
                    tdf_pkg::CFG_FILTER_STEP:  filt_reg  <= cfg_data[SW-1:0];
                    default: ;
                endcase
            end
            if (cmd.mul_take && cmd.sel == tdf_pkg::MS_POS) begin
                pos_reg <= sat_dw(pos_sum);
            end
            if (cmd.mul_take && cmd.sel == tdf_pkg::MS_RATE) begin
                rate_reg <= sat_dw(rate_sum);
            end
            if (cmd.out_load) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            err_reg <= {{(XW+1-DW){pos_reg[DW-1]}}, pos_reg}
                     - {{(XW-31){s_target[31]}}, s_target};
        end
        if (cmd.mul_take) begin
            case (cmd.sel)
                tdf_pkg::MS_H0SQ: h0sq_reg <= prod[2*FW-1:FW];
                tdf_pkg::MS_GAIN: d_reg    <= (gain == '0) ? 32'd1 : gain;
                tdf_pkg::MS_A0:   a0_reg   <= rate_reg[DW-1] ? -signed'(pmag) : signed'(pmag);
                default: ;
            endcase
        end
        if (cmd.y_take) begin
            y_reg <= (XW+2)'(err_reg) + (XW+2)'(a0_reg);
        end
        if (cmd.half_take) begin
            // The root is never below d, so this difference cannot go negative.
            half_reg <= (res_reg[RTW-1:0] - RTW'(d_reg)) >> 1;
        end
        if (cmd.a_take) begin
            a_reg <= y_in ? a0y : a2;
        end
        if (cmd.fh_sat) begin
            fhmag_reg <= speed_reg;
            fhneg_reg <= !a_reg[SAW-1];
        end else if (cmd.fh_take) begin
            fhmag_reg <= res_reg[31:0];
            fhneg_reg <= !a_reg[SAW-1];
        end
        if (cmd.out_load) begin
            tv_reg <= sat32(pos_reg);
            tr_reg <= sat32(rate_reg);
        end
    end

    assign status.mul_done   = mul_done;
    assign status.iter_done  = idone_reg;
    assign status.a_in_range = (a_reg >= -d_sa) && (a_reg < d_sa);
    assign status.out_free   = !mv_reg || m_ready;

    assign m_valid         = mv_reg;
    assign m_tracked_value = tv_reg;
    assign m_tracked_rate  = tr_reg;

`ifndef SYNTH
    ast_mul_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_start |-> !mul_busy)
        else $error("multiplier started while busy");
    ast_iter_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.root_start || cmd.div_start) |-> !ibusy_reg)
        else $error("root or divide started while busy");
    ast_gain_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.mul_take && cmd.sel == tdf_pkg::MS_GAIN) |=> (d_reg != '0))
        else $error("fhan gain left at zero");
    ast_quot_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (idone_reg && !iroot_reg) |-> (res_reg[QW-1:32] == '0))
        else $error("acceleration quotient exceeds 32 bits");
`endif

endmodule

// ===== sv/tdf_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdf_ctrl
// Sequencer that walks one target sample through the datapath operations.
// ----------------------------------------------------------------------------
module tdf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tdf_pkg::status_t  status,
    output tdf_pkg::cmd_t     cmd
);
    tdf_pkg::state_t   state_reg, state_next;
    tdf_pkg::mul_sel_t sel_reg, sel_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tdf_pkg::S_IDLE;
            sel_reg   <= tdf_pkg::MS_H0SQ;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.sel    = sel_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            tdf_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    sel_next   = tdf_pkg::MS_H0SQ;
                    state_next = tdf_pkg::S_MUL;
                end
            end
            tdf_pkg::S_MUL: begin
                cmd.mul_start = 1'b1;
                state_next    = tdf_pkg::S_MWAIT;
            end
            tdf_pkg::S_MWAIT: begin
                if (status.mul_done) begin
                    unique case (sel_reg)
                        tdf_pkg::MS_H0SQ: begin
                            cmd.mul_take = 1'b1;
                            sel_next     = tdf_pkg::MS_GAIN;
                            state_next   = tdf_pkg::S_MUL;
                        end
                        tdf_pkg::MS_GAIN: begin
                            cmd.mul_take = 1'b1;
                            sel_next     = tdf_pkg::MS_A0;
                            state_next   = tdf_pkg::S_MUL;
                        end
                        tdf_pkg::MS_A0: begin
                            cmd.mul_take = 1'b1;
                            state_next   = tdf_pkg::S_PREP;
                        end
                        tdf_pkg::MS_RAD: begin
                            cmd.root_start = 1'b1;
                            state_next     = tdf_pkg::S_ROOT;
                        end
                        tdf_pkg::MS_QN: begin
                            cmd.div_start = 1'b1;
                            state_next    = tdf_pkg::S_DIV;
                        end
                        tdf_pkg::MS_POS: begin
                            cmd.mul_take = 1'b1;
                            sel_next     = tdf_pkg::MS_RATE;
                            state_next   = tdf_pkg::S_MUL;
                        end
                        tdf_pkg::MS_RATE: begin
                            cmd.mul_take = 1'b1;
                            state_next   = tdf_pkg::S_OUT;
                        end
                        default: state_next = tdf_pkg::S_IDLE;
                    endcase
                end
            end
            tdf_pkg::S_PREP: begin
                cmd.y_take = 1'b1;
                sel_next   = tdf_pkg::MS_RAD;
                state_next = tdf_pkg::S_MUL;
            end
            tdf_pkg::S_ROOT: begin
                if (status.iter_done) begin
                    state_next = tdf_pkg::S_HALF;
                end
            end
            tdf_pkg::S_HALF: begin
                cmd.half_take = 1'b1;
                state_next    = tdf_pkg::S_AREG;
            end
            tdf_pkg::S_AREG: begin
                cmd.a_take = 1'b1;
                state_next = tdf_pkg::S_ASEL;
            end
            tdf_pkg::S_ASEL: begin
                // Inside the linear zone the acceleration needs the divide;
                // outside it is simply the speed factor with the sign opposite to a.
                if (status.a_in_range) begin
                    sel_next = tdf_pkg::MS_QN;
                end else begin
                    cmd.fh_sat = 1'b1;
                    sel_next   = tdf_pkg::MS_POS;
                end
                state_next = tdf_pkg::S_MUL;
            end
            tdf_pkg::S_DIV: begin
                if (status.iter_done) begin
                    cmd.fh_take = 1'b1;
                    sel_next    = tdf_pkg::MS_POS;
                    state_next  = tdf_pkg::S_MUL;
                end
            end
            tdf_pkg::S_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = tdf_pkg::S_IDLE;
                end
            end
            default: state_next = tdf_pkg::S_IDLE;
        endcase
    end

endmodule

// ===== test/tdf_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tdf_checker
// Predicts and checks the result beats of the tracking differentiator.
// ----------------------------------------------------------------------------
// Follows configuration writes and accepted target beats, keeps its own copy
// of the tracked value and derivative, and compares every result beat with
// the oldest prediction. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module tdf_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [tdf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tdf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic signed [31:0]             s_target,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic signed [31:0]             m_tracked_value,
    input  logic signed [31:0]             m_tracked_rate,
    output int                             fail_count,
    output int                             pending,
    output int                             results_seen
);
    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] rate;
    } track_t;

    track_t           want_q[$];
    logic [23:0]      h_step;
    logic [31:0]      r_speed;
    logic [23:0]      h_filter;
    longint           pos_st;
    longint           rate_st;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Signed value times an unsigned Q0.24 fraction, truncated toward zero.
    function automatic longint frac_mul(longint x, logic [23:0] f);
        logic [127:0] m;
        logic [127:0] p;
        m = (x < 0) ? 128'(-x) : 128'(x);
        p = (m * 128'(f)) >> tdf_pkg::FRAC_W;
        return (x < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic [63:0] isqrt(logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= n) r = c;
        end
        return r;
    endfunction

    function automatic longint fhan_accel(longint err, longint rt);
        longint d, a0, y, ay, a1, half, a;
        logic [63:0] h0sq;
        logic [127:0] q;
        h0sq = (64'(h_filter) * 64'(h_filter)) >> tdf_pkg::FRAC_W;
        d = frac_mul(longint'(r_speed), h0sq[23:0]);
        if (d < 1) d = 1;
        a0 = frac_mul(rt, h_filter);
        y = err + a0;
        ay = (y < 0) ? -y : y;
        a1 = longint'(isqrt(128'(d) * (128'(d) + 128'(8) * 128'(ay))));
        half = (a1 - d) / 2;
        if (half < 0) half = 0;
        a = (y >= -d && y < d) ? a0 + y : ((y >= 0) ? a0 + half : a0 - half);
        if (a >= -d && a < d) begin
            q = (128'(r_speed) * 128'((a < 0) ? -a : a)) / 128'(d);
            return (a < 0) ? longint'(q) : -longint'(q);
        end
        return (a >= 0) ? -longint'(r_speed) : longint'(r_speed);
    endfunction

    always @(posedge aclk) begin
        longint fh, np, nr;
        track_t got, want;
        int     fails;
        fails = 0;
        if (!aresetn) begin
            h_step   <= tdf_pkg::STEP_TIME_RESET;
            r_speed  <= tdf_pkg::SPEED_FACTOR_RESET;
            h_filter <= tdf_pkg::FILTER_STEP_RESET;
            pos_st   = 0;
            rate_st  = 0;
            want_q.delete();
            fail_count   <= 0;
            results_seen <= 0;
            pending      <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    tdf_pkg::CFG_STEP_TIME:    h_step   <= cfg_data[23:0];
                    tdf_pkg::CFG_SPEED_FACTOR: r_speed  <= cfg_data;
                    tdf_pkg::CFG_FILTER_STEP:  h_filter <= cfg_data[23:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                fh = fhan_accel(pos_st - longint'(s_target), rate_st);
                np = sat32(pos_st + frac_mul(rate_st, h_step));
                nr = sat32(rate_st + frac_mul(fh, h_step));
                pos_st = np;
                rate_st = nr;
                want.value = np[31:0];
                want.rate = nr[31:0];
                want_q.push_back(want);
            end
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                got.value = m_tracked_value;
                got.rate = m_tracked_rate;
                if (want_q.size() == 0) begin
                    $error("result beat with no prediction waiting");
                    fails++;
                end else begin
                    want = want_q.pop_front();
                    if (got.value !== want.value) begin
                        $error("tracked_value expected %0d actual %0d", want.value, got.value);
                        fails++;
                    end
                    if (got.rate !== want.rate) begin
                        $error("tracked_rate expected %0d actual %0d", want.rate, got.rate);
                        fails++;
                    end
                end
            end
            fail_count <= fail_count + fails;
            pending    <= want_q.size();
        end
    end
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the tracking differentiator.
// ----------------------------------------------------------------------------
// Drives directed and random target beats under several register settings,
// with random idling on both channels, a long output hold-off and a drain
// pause. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    localparam int LIMIT_CYCLES = 2_000_000;

    // A register index with no register behind it.
    localparam logic [tdf_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [tdf_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tdf_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           s_valid;
    logic                           s_ready;
    logic signed [31:0]             s_target;
    logic                           m_valid;
    logic                           m_ready;
    logic signed [31:0]             m_tracked_value;
    logic signed [31:0]             m_tracked_rate;
    int                             fail_count;
    int                             pending;
    int                             results_seen;
    int                             cycle_count;
    int                             hold_off;
    bit                             calm;
    int                             beats_sent;

    tracking_differentiator_fhan uut (.*);

    tdf_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Receiver: random stalls, or none in the calm stretch, and a long hold-off.
    initial begin
        m_ready <= 1'b0;
        hold_off = 0;
        forever begin
            @(posedge aclk);
            if (hold_off > 0) begin
                hold_off--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 38);
            end
        end
    end

    task automatic write_reg(input logic [tdf_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // The beat stays offered after acceptance until the next call or a drain
    // takes valid down, so valid is never driven twice in one time step.
    task automatic send_target(input logic signed [31:0] tgt);
        if (!calm) begin
            while ($urandom_range(99) < 38) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid  <= 1'b1;
        s_target <= tgt;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] rand_target();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(65536 * 20)) - 32'sd655360;
            2: return ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom) >>> $urandom_range(31);
        endcase
    endfunction

    task automatic set_regs(input logic [31:0] h, input logic [31:0] r, input logic [31:0] h0);
        drain();
        write_reg(tdf_pkg::CFG_STEP_TIME, h);
        write_reg(tdf_pkg::CFG_SPEED_FACTOR, r);
        write_reg(tdf_pkg::CFG_FILTER_STEP, h0);
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_target  <= '0;
        calm = 1'b0;
        beats_sent = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset settings with field extremes.
        send_target(32'sd0);
        send_target(32'sh7fffffff);
        send_target(32'sh80000000);
        send_target(32'sd65536);
        send_target(-32'sd65536);
        send_target(32'sd1);
        send_target(-32'sd1);
        // Tiny gain, so the filter product truncates to zero.
        set_regs(32'd16777, 32'd1, 32'd1);
        send_target(32'sd655360);
        send_target(-32'sd655360);
        // Largest registers, driving the state into saturation.
        set_regs(32'hffffff, 32'hffffffff, 32'hffffff);
        repeat (6) send_target(32'sh7fffffff);
        repeat (6) send_target(32'sh80000000);
        // An out-of-range index must be ignored.
        drain();
        write_reg(CFG_UNUSED, 32'hdeadbeef);
        send_target(32'sd12345);

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_regs(tdf_pkg::STEP_TIME_RESET, tdf_pkg::SPEED_FACTOR_RESET,
                            tdf_pkg::FILTER_STEP_RESET);
                1: set_regs(32'd1, 32'd1, 32'hffffff);
                2: set_regs($urandom, $urandom, $urandom);
                3: set_regs(32'hffffff, 32'hffffffff, 32'd1);
                default: set_regs($urandom_range(24'hffffff, 1), $urandom_range(32'hffffffff, 1),
                                  $urandom_range(24'hffffff, 1));
            endcase
            calm = (phase == 5);
            if (phase == 3) begin
                hold_off = 2000;
            end
            for (int k = 0; k < 250; k++) send_target(rand_target());
            calm = 1'b0;
        end

        drain();
        $display("Covered %0d target beats, %0d results, over eleven register settings.",
                 beats_sent, results_seen);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
